/* rtl/wema_pkg.sv */
// Package with payload types, sequencer states and constants of the error metrics accumulator.
package wema_pkg;

   typedef struct packed {
      logic signed [15:0] sample_ref;
      logic signed [15:0] sample_approx;
      logic        [15:0] weight;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic        [47:0] elem_sum_sq_error;
      logic        [31:0] elem_max_sq_error;
      logic        [62:0] total_weighted_sq_error;
      logic        [39:0] total_weight;
      logic        [15:0] max_abs_error;
      logic signed [15:0] y_min;
      logic signed [15:0] y_max;
      logic        [31:0] vector_count;
      logic        [31:0] rmse;
      logic        [31:0] nrmse;
      logic signed [15:0] psnr_db;
      logic               vector_done;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_ELEM,
      ST_WACC,
      ST_DEN,
      ST_DIV,
      ST_SQRT,
      ST_NRM,
      ST_LNORM,
      ST_LSQ,
      ST_LPOST,
      ST_PMUL,
      ST_PFIN,
      ST_DONE
   } state_type;

   // 20*log10(2) in Q16.16.
   localparam logic [31:0] LOG_K = 32'd394566;
   localparam logic signed [15:0] PSNR_MAX = 16'sh7FFF;
   localparam logic signed [15:0] PSNR_MIN = -16'sh8000;
   localparam logic [6:0] DIM_RESET = 7'd64;

endpackage

/* rtl/weighted_error_metrics_accumulator_unit.sv */
// Top level of the weighted error metrics accumulator with its shared sequenced datapath.
//
// Usage: each input item on req_* carries one vector element (reference and
// approximated sample, Q8.8 vector weight, last-element flag). Every item
// gives exactly one result item on rsp_*: the statistics at that element's
// index, the global accumulators and the metrics (RMSE, NRMSE, PSNR) as held
// since the last vector end.
// Timing: req_ready is high only while the sequencer is idle and out of reset.
// An item that does not end a vector passes the states ERR, ELEM, WACC and DONE
// to the result register; the next item is taken only once the sequencer is idle again.
// An item that ends a vector also runs the metric sequence on the one shared 32x32
// multiplier: shift-and-add for the divisor, 64 divide steps, 32 root steps,
// 32 NRMSE divide steps and two logarithms (up to 31 normalize steps plus 16
// squarings each); a zero or saturating case skips parts of this sequence.
// The result register decouples the two sides: a new item is accepted while
// an older result still waits for rsp_ready; the sequencer only holds in its
// final state if the result register is still occupied.
// Reset clears the accumulators except the element sum and maximum, the valid
// bits (so the per-index stores read as zero), the metrics and sets vector_dimension to 64.
// csr_wr_en writes vector_dimension; write it only while the block is idle.
module weighted_error_metrics_accumulator_unit #(
   parameter int DIM_MAX = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wema_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wema_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [6:0]        csr_wr_data
);

   localparam int POS_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIM_MAX - 1);

   // Sequencer and item registers.
   wema_pkg::state_type state_ff, state_in;
   wema_pkg::req_type   item_ff, item_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   // Per-index store: sum of squared errors and maximum, with valid bits.
   logic [79:0]         mem [DIM_MAX];
   logic [DIM_MAX-1:0]  valid_ff;
   logic [79:0]         rd_ff;
   logic                rdv_ff;
   logic                mem_we;

   // Accumulators.
   logic [47:0]         esum_ff, esum_in;
   logic [31:0]         emax_ff, emax_in;
   logic [62:0]         wsum_ff, wsum_in;
   logic [39:0]         wtot_ff, wtot_in;
   logic [15:0]         amax_ff, amax_in;
   logic signed [15:0]  ymin_ff, ymin_in, ymax_ff, ymax_in;
   logic                seen_ff, seen_in;
   logic [31:0]         vcnt_ff, vcnt_in;
   logic [31:0]         rmse_ff, rmse_in, nrmse_ff, nrmse_in;
   logic signed [15:0]  psnr_ff, psnr_in;
   logic [6:0]          dim_ff;

   // Work registers of the metric sequence.
   logic [5:0]          iter_ff, iter_in;
   logic [46:0]         den_ff, den_in;
   logic [47:0]         rem_ff, rem_in;
   logic [63:0]         num_ff, num_in, quo_ff, quo_in, res_ff, res_in, bit_ff, bit_in;
   logic [15:0]         range_ff, range_in, nrem_ff, nrem_in;
   logic [31:0]         dq_ff, dq_in, lx_ff, lx_in;
   logic [4:0]          ln_ff, ln_in;
   logic [15:0]         lfrac_ff, lfrac_in;
   logic [20:0]         la_ff, la_in;
   logic                lsecond_ff, lsecond_in, neg_ff, neg_in;

   // Shared multiplier with registered product.
   logic [31:0]         mul_a, mul_b;
   logic [63:0]         prod_ff;

   // Result register.
   wema_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wema_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      logic [16:0] diff17;
      logic [15:0] ad;
      logic [31:0] e2;
      logic [47:0] old_sum;
      logic [31:0] old_max;
      logic [48:0] s49;
      logic [63:0] s64;
      logic [40:0] s41;
      logic [16:0] r17y;
      logic [7:0]  dim8;
      logic [47:0] rdiv;
      logic        ge;
      logic [63:0] tsq;
      logic [16:0] r17;
      logic [32:0] t33;
      logic [20:0] lb;
      logic [20:0] lmag;
      logic [40:0] rnd;
      logic [16:0] pmag;
      logic        go_nrm;
      logic [31:0] nrm_src;
      logic        go_psnr;

      state_in     = state_ff;
      item_in      = item_ff;
      pos_in       = pos_ff;
      esum_in      = esum_ff;
      emax_in      = emax_ff;
      wsum_in      = wsum_ff;
      wtot_in      = wtot_ff;
      amax_in      = amax_ff;
      ymin_in      = ymin_ff;
      ymax_in      = ymax_ff;
      seen_in      = seen_ff;
      vcnt_in      = vcnt_ff;
      rmse_in      = rmse_ff;
      nrmse_in     = nrmse_ff;
      psnr_in      = psnr_ff;
      iter_in      = iter_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      range_in     = range_ff;
      nrem_in      = nrem_ff;
      dq_in        = dq_ff;
      lx_in        = lx_ff;
      ln_in        = ln_ff;
      lfrac_in     = lfrac_ff;
      la_in        = la_ff;
      lsecond_in   = lsecond_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a        = '0;
      mul_b        = '0;
      mem_we       = 1'b0;
      req_ready    = 1'b0;
      go_nrm       = 1'b0;
      nrm_src      = '0;
      go_psnr      = 1'b0;

      diff17  = {item_ff.sample_approx[15], item_ff.sample_approx}
              - {item_ff.sample_ref[15], item_ff.sample_ref};
      ad      = diff17[16] ? 16'(-diff17) : diff17[15:0];
      e2      = prod_ff[31:0];
      old_sum = rdv_ff ? rd_ff[79:32] : '0;
      old_max = rdv_ff ? rd_ff[31:0] : '0;
      s49     = {1'b0, old_sum} + {17'b0, e2};
      s64     = {1'b0, wsum_ff} + {16'b0, prod_ff[47:0]};
      s41     = {1'b0, wtot_ff} + {25'b0, item_ff.weight};
      r17y    = {ymax_ff[15], ymax_ff} - {ymin_ff[15], ymin_ff};
      dim8    = (dim_ff == '0) ? 8'd1 : {1'b0, dim_ff};
      rdiv    = {rem_ff[46:0], num_ff[63]};
      ge      = rdiv >= {1'b0, den_ff};
      tsq     = res_ff + bit_ff;
      r17     = {nrem_ff, dq_ff[31]};
      t33     = prod_ff[63:31];
      lb      = {ln_ff, lfrac_ff};
      lmag    = (la_ff < lb) ? (lb - la_ff) : (la_ff - lb);
      rnd     = prod_ff[40:0] + 41'd8388608;
      pmag    = rnd[40:24];

      unique case (state_ff)
         wema_pkg::ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               item_in  = req_data;
               state_in = wema_pkg::ST_ERR;
            end
         end
         wema_pkg::ST_ERR: begin
            mul_a = {16'b0, ad};
            mul_b = {16'b0, ad};
            if (ad > amax_ff) amax_in = ad;
            if (!seen_ff) begin
               ymin_in = item_ff.sample_ref;
               ymax_in = item_ff.sample_ref;
               seen_in = 1'b1;
            end else begin
               if (item_ff.sample_ref < ymin_ff) ymin_in = item_ff.sample_ref;
               if (item_ff.sample_ref > ymax_ff) ymax_in = item_ff.sample_ref;
            end
            state_in = wema_pkg::ST_ELEM;
         end
         wema_pkg::ST_ELEM: begin
            esum_in  = s49[48] ? '1 : s49[47:0];
            emax_in  = (e2 > old_max) ? e2 : old_max;
            mem_we   = 1'b1;
            mul_a    = {16'b0, item_ff.weight};
            mul_b    = e2;
            state_in = wema_pkg::ST_WACC;
         end
         wema_pkg::ST_WACC: begin
            wsum_in = s64[63] ? '1 : s64[62:0];
            if (item_ff.last_element) begin
               wtot_in  = s41[40] ? '1 : s41[39:0];
               if (vcnt_ff != '1) vcnt_in = vcnt_ff + 32'd1;
               pos_in   = '0;
               range_in = r17y[15:0];
               den_in   = '0;
               iter_in  = '0;
               state_in = wema_pkg::ST_DEN;
            end else begin
               pos_in   = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);
               state_in = wema_pkg::ST_DONE;
            end
         end
         wema_pkg::ST_DEN: begin
            // Weight sum times dimension by shift and add, one bit a cycle.
            if (iter_ff < 6'd7) begin
               if (dim8[iter_ff[2:0]]) begin
                  den_in = den_ff + ({7'b0, wtot_ff} << iter_ff[2:0]);
               end
               iter_in = iter_ff + 6'd1;
            end else if (wtot_ff == '0) begin
               go_nrm  = 1'b1;
               nrm_src = '0;
            end else if ({16'b0, wsum_ff[62:32]} >= den_ff) begin
               go_nrm  = 1'b1;
               nrm_src = '1;
            end else begin
               rem_in   = {17'b0, wsum_ff[62:32]};
               num_in   = {wsum_ff[31:0], 32'b0};
               quo_in   = '0;
               iter_in  = '0;
               state_in = wema_pkg::ST_DIV;
            end
         end
         wema_pkg::ST_DIV: begin
            rem_in  = ge ? (rdiv - {1'b0, den_ff}) : rdiv;
            num_in  = {num_ff[62:0], 1'b0};
            quo_in  = {quo_ff[62:0], ge};
            iter_in = iter_ff + 6'd1;
            if (iter_ff == 6'd63) begin
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               iter_in  = '0;
               state_in = wema_pkg::ST_SQRT;
            end
         end
         wema_pkg::ST_SQRT: begin
            // The quotient register now holds the radicand remainder.
            if (quo_ff >= tsq) begin
               quo_in = quo_ff - tsq;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff + 6'd1;
            if (iter_ff == 6'd31) begin
               go_nrm  = 1'b1;
               nrm_src = res_in[31:0];
            end
         end
         wema_pkg::ST_NRM: begin
            if (range_ff == '0) begin
               nrmse_in = (rmse_ff != '0) ? '1 : '0;
               go_psnr  = 1'b1;
            end else begin
               if (r17 >= {1'b0, range_ff}) begin
                  nrem_in = 16'(r17 - {1'b0, range_ff});
                  dq_in   = {dq_ff[30:0], 1'b1};
               end else begin
                  nrem_in = r17[15:0];
                  dq_in   = {dq_ff[30:0], 1'b0};
               end
               iter_in = iter_ff + 6'd1;
               if (iter_ff == 6'd31) begin
                  nrmse_in = dq_in;
                  go_psnr  = 1'b1;
               end
            end
         end
         wema_pkg::ST_LNORM: begin
            if (lx_ff[31]) begin
               iter_in  = '0;
               state_in = wema_pkg::ST_LSQ;
            end else begin
               lx_in = {lx_ff[30:0], 1'b0};
               ln_in = ln_ff - 5'd1;
            end
         end
         wema_pkg::ST_LSQ: begin
            mul_a    = lx_ff;
            mul_b    = lx_ff;
            state_in = wema_pkg::ST_LPOST;
         end
         wema_pkg::ST_LPOST: begin
            lfrac_in = {lfrac_ff[14:0], t33[32]};
            lx_in    = t33[32] ? t33[32:1] : t33[31:0];
            iter_in  = iter_ff + 6'd1;
            state_in = wema_pkg::ST_LSQ;
            if (iter_ff == 6'd15) begin
               if (!lsecond_ff) begin
                  la_in      = {ln_ff, lfrac_in};
                  lx_in      = rmse_ff;
                  ln_in      = 5'd31;
                  lfrac_in   = '0;
                  lsecond_in = 1'b1;
                  state_in   = wema_pkg::ST_LNORM;
               end else begin
                  state_in = wema_pkg::ST_PMUL;
               end
            end
         end
         wema_pkg::ST_PMUL: begin
            neg_in   = la_ff < lb;
            mul_a    = {11'b0, lmag};
            mul_b    = wema_pkg::LOG_K;
            state_in = wema_pkg::ST_PFIN;
         end
         wema_pkg::ST_PFIN: begin
            if (!neg_ff) begin
               psnr_in = (pmag > 17'd32767) ? wema_pkg::PSNR_MAX : $signed(pmag[15:0]);
            end else begin
               psnr_in = (pmag > 17'd32768) ? wema_pkg::PSNR_MIN : $signed(16'(-pmag));
            end
            state_in = wema_pkg::ST_DONE;
         end
         wema_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.elem_sum_sq_error       = esum_ff;
               rsp_in.elem_max_sq_error       = emax_ff;
               rsp_in.total_weighted_sq_error = wsum_ff;
               rsp_in.total_weight            = wtot_ff;
               rsp_in.max_abs_error           = amax_ff;
               rsp_in.y_min                   = ymin_ff;
               rsp_in.y_max                   = ymax_ff;
               rsp_in.vector_count            = vcnt_ff;
               rsp_in.rmse                    = rmse_ff;
               rsp_in.nrmse                   = nrmse_ff;
               rsp_in.psnr_db                 = psnr_ff;
               rsp_in.vector_done             = item_ff.last_element;
               rsp_valid_in                   = 1'b1;
               state_in                       = wema_pkg::ST_IDLE;
            end
         end
         default: state_in = wema_pkg::ST_IDLE;
      endcase

      // Latch RMSE and start the NRMSE division.
      if (go_nrm) begin
         rmse_in  = nrm_src;
         nrem_in  = '0;
         dq_in    = nrm_src;
         iter_in  = '0;
         state_in = wema_pkg::ST_NRM;
      end

      // PSNR: maximum for a zero error, zero for a flat reference, else two logarithms.
      if (go_psnr) begin
         if (rmse_ff == '0) begin
            psnr_in  = wema_pkg::PSNR_MAX;
            state_in = wema_pkg::ST_DONE;
         end else if (range_ff == '0) begin
            psnr_in  = '0;
            state_in = wema_pkg::ST_DONE;
         end else begin
            lx_in      = {range_ff, 16'b0};
            ln_in      = 5'd31;
            lfrac_in   = '0;
            lsecond_in = 1'b0;
            state_in   = wema_pkg::ST_LNORM;
         end
      end
   end

   // Per-index store with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pos_ff] <= {esum_in, emax_in};
      end
      rd_ff  <= mem[pos_ff];
      rdv_ff <= valid_ff[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[pos_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         wsum_ff      <= '0;
         wtot_ff      <= '0;
         amax_ff      <= '0;
         ymin_ff      <= '0;
         ymax_ff      <= '0;
         seen_ff      <= 1'b0;
         vcnt_ff      <= '0;
         rmse_ff      <= '0;
         nrmse_ff     <= '0;
         psnr_ff      <= '0;
         dim_ff       <= wema_pkg::DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         wsum_ff      <= wsum_in;
         wtot_ff      <= wtot_in;
         amax_ff      <= amax_in;
         ymin_ff      <= ymin_in;
         ymax_ff      <= ymax_in;
         seen_ff      <= seen_in;
         vcnt_ff      <= vcnt_in;
         rmse_ff      <= rmse_in;
         nrmse_ff     <= nrmse_in;
         psnr_ff      <= psnr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            dim_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      esum_ff    <= esum_in;
      emax_ff    <= emax_in;
      iter_ff    <= iter_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      res_ff     <= res_in;
      bit_ff     <= bit_in;
      range_ff   <= range_in;
      nrem_ff    <= nrem_in;
      dq_ff      <= dq_in;
      lx_ff      <= lx_in;
      ln_ff      <= ln_in;
      lfrac_ff   <= lfrac_in;
      la_ff      <= la_in;
      lsecond_ff <= lsecond_in;
      neg_ff     <= neg_in;
      prod_ff    <= mul_a * mul_b;
      rsp_ff     <= rsp_in;
   end

   // An accepted item occupies the sequencer for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted twice in a row");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("element index beyond store depth");

   a_count_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.vector_done |-> rsp_data.vector_count != '0)
      else $error("vector end reported with zero vector count");

   a_y_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.y_min <= rsp_data.y_max)
      else $error("reference minimum above maximum");

endmodule
